### design/utf16_to_utf8_transcoder_unit_macros.svh
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent assertion forms for the transcoder unit.
// ---------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH

// same-cycle implication
`define U16U8_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("transcoder assertion failed");

// next-cycle implication
`define U16U8_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("transcoder assertion failed");

`endif

### design/u16u8_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Types, constants and the code point encoder shared by the transcoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned MAX_BYTES  = 6;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [15:0] SURR_MASK = 16'hfc00;
  localparam logic [15:0] HIGH_TAG  = 16'hd800;
  localparam logic [15:0] LOW_TAG   = 16'hdc00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    MODE_UNIT    = 2'd0,
    MODE_BYTE_LE = 2'd1,
    MODE_BYTE_BE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      num;
  } enc_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          num;
  } job_t;

  typedef struct packed {
    logic half_valid;
    logic held_valid;
  } front_stat_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= 21'h7f) begin
      e.bytes[0] = cp[7:0];
      e.num      = 3'd1;
    end else if (cp <= 21'h7ff) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.num      = 3'd2;
    end else if (cp <= 21'hffff) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.num      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.num      = 3'd4;
    end
    return e;
  endfunction

endpackage

### design/u16u8_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Transcoder front end
// Pairs bytes into code units, tracks the held high surrogate and turns each
// word into at most one job of up to six UTF-8 bytes.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [15:0]               code_unit_i,
  input  logic                      eot_i,
  input  logic                      full_i,
  output logic                      push_o,
  output u16u8_pkg::job_t           job_o,
  output u16u8_pkg::front_stat_t    stat_o
);
  import u16u8_pkg::*;

  mode_e       mode_q;
  logic [7:0]  half_byte_q, half_byte_d;
  logic        half_valid_q, half_valid_d;
  logic [15:0] held_q, held_d;

  logic        accept, unit_go, is_high, is_low;
  logic [7:0]  b;
  logic [15:0] w, held_nxt;
  logic [20:0] cmb, e1cp, e2cp;
  logic        e1v, e2v;
  enc_t        enc1, enc2;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    b       = code_unit_i[7:0];
    unit_go = !(mode_q == MODE_BYTE_LE || mode_q == MODE_BYTE_BE) || half_valid_q;
    case (mode_q)
      MODE_BYTE_LE: w = {b, half_byte_q};
      MODE_BYTE_BE: w = {half_byte_q, b};
      default:      w = code_unit_i;
    endcase
    is_high = (w & SURR_MASK) == HIGH_TAG;
    is_low  = (w & SURR_MASK) == LOW_TAG;
    cmb     = {1'b0, held_q[9:0], w[9:0]} + SUPP_BASE;

    e1v      = 1'b0;
    e2v      = 1'b0;
    e1cp     = '0;
    e2cp     = '0;
    held_nxt = held_q;
    if (unit_go) begin
      if (held_q != '0) begin
        e1v = 1'b1;
        if (is_low) begin
          e1cp     = cmb;
          held_nxt = '0;
        end else begin
          e1cp = {5'b0, held_q};
          if (is_high) begin
            held_nxt = w;
          end else begin
            held_nxt = '0;
            e2v      = 1'b1;
            e2cp     = {5'b0, w};
          end
        end
      end else if (is_high) begin
        held_nxt = w;
      end else begin
        e1v  = 1'b1;
        e1cp = {5'b0, w};
      end
    end
    if (eot_i && held_nxt != '0) begin
      if (!e1v) begin
        e1v  = 1'b1;
        e1cp = {5'b0, held_nxt};
      end else begin
        e2v  = 1'b1;
        e2cp = {5'b0, held_nxt};
      end
      held_nxt = '0;
    end

    enc1 = encode_cp(e1cp);
    enc2 = encode_cp(e2cp);
    job_o.bytes[0] = enc1.bytes[0];
    job_o.bytes[1] = enc1.bytes[1];
    job_o.bytes[2] = enc1.bytes[2];
    job_o.bytes[3] = e2v ? enc2.bytes[0] : enc1.bytes[3];
    job_o.bytes[4] = enc2.bytes[1];
    job_o.bytes[5] = enc2.bytes[2];
    job_o.num      = e2v ? CNT_W'(3) + enc2.num : enc1.num;

    half_byte_d  = half_byte_q;
    half_valid_d = half_valid_q;
    held_d       = held_q;
    if (accept) begin
      held_d = held_nxt;
      if (unit_go) begin
        half_valid_d = 1'b0;
      end else begin
        half_byte_d  = b;
        half_valid_d = !eot_i;
      end
    end
  end

  assign push_o            = accept && e1v;
  assign stat_o.half_valid = half_valid_q;
  assign stat_o.held_valid = held_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_UNIT;
      half_byte_q  <= '0;
      half_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      half_byte_q  <= half_byte_d;
      half_valid_q <= half_valid_d;
      held_q       <= held_d;
    end
  end

endmodule

### design/u16u8_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Transcoder job queue
// Short first-in first-out queue of jobs between front and back end.
// ---------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned Depth = u16u8_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t wr_job_i,
  input  logic            pop_i,
  output u16u8_pkg::job_t rd_job_o,
  output logic            full_o,
  output logic            empty_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o   = cnt_q == CntW'(Depth);
  assign empty_o  = cnt_q == '0;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### design/u16u8_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Transcoder back end
// Sends a held job's bytes one per ready cycle, marking the final byte.
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u16u8_pkg::job_t job_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import u16u8_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BYTES);

  job_t             job_q;
  logic             valid_q;
  logic [CNT_W-1:0] idx_q;
  logic             accept, load;

  assign out_valid_o = valid_q;
  assign out_byte_o  = job_q.bytes[idx_q[IdxW-1:0]];
  assign out_last_o  = idx_q == job_q.num - CNT_W'(1);
  assign accept      = valid_q && out_ready_i;
  assign load        = !valid_q || (accept && out_last_o);
  assign pop_o       = load && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
        idx_q   <= '0;
      end else if (accept) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

endmodule

### design/utf16_to_utf8_transcoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder unit
// Converts a stream of UTF-16 code units or byte pairs into UTF-8 bytes.
// ---------------------------------------------------------------------------
// Each input word is decoded by the front end in the cycle it is accepted
// and queued as a job of one to six bytes; the back end sends one output
// byte per cycle while m_axis_tready is high (none for a first byte of a
// pair or a stored high surrogate). The input takes a word every cycle while
// the job queue (FifoDepth jobs) has room, and a new job follows the last
// byte of the previous one with no gap if one is queued. tlast marks the
// final output byte caused by one input word. The user writes input_mode
// via cfg_we_i/cfg_wdata_i only while the stream idles (not enforced).
module utf16_to_utf8_transcoder_unit #(
  parameter int unsigned FifoDepth = u16u8_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // input_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] code_unit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tlast
);
  import u16u8_pkg::*;

`include "utf16_to_utf8_transcoder_unit_macros.svh"

  job_t        push_job, pop_job;
  logic        push, pop, full, empty;
  front_stat_t fstat;
  logic        eot_accept, front_idle, job_len_ok;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .code_unit_i (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job),
    .stat_o      (fstat)
  );

  u16u8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_job_i (push_job),
    .pop_i    (pop),
    .rd_job_o (pop_job),
    .full_o   (full),
    .empty_o  (empty)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign eot_accept = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign front_idle = !fstat.half_valid && !fstat.held_valid;
  assign job_len_ok = push_job.num != '0 && push_job.num <= CNT_W'(MAX_BYTES);

  `U16U8_ASSERT_NEXT(a_eot_flush, clk_i, rst_ni, eot_accept, front_idle)
  `U16U8_ASSERT_NEXT(a_back_refill, clk_i, rst_ni, !m_axis_tvalid && !empty, m_axis_tvalid)
  `U16U8_ASSERT_IMPL(a_job_len, clk_i, rst_ni, push, job_len_ok)

endmodule
